FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the key matrix debounce reporter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked while reset is released.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/kmdr_pkg.sv
// Shared types, constants and functions of the key matrix debounce reporter.
// Used by kmdr_in_stage, kmdr_scan_core and key_matrix_debounce_reporter.
package kmdr_pkg;

	localparam int SELECT_COUNT = 8;
	localparam int SENSE_COUNT  = 7;
	localparam int ROW_LENGTH   = 14;
	localparam int ROW_COUNT    = 4;
	localparam int KEY_BITS     = SELECT_COUNT * SENSE_COUNT;
	localparam int KEY_IDX_W    = $clog2(KEY_BITS);
	localparam int TIME_W       = 32;
	localparam int PERIOD_W     = 8;
	localparam int ROW_W        = 2;
	localparam int COL_W        = 4;
	localparam int MOD_W        = 4;

	localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET = 8'd5;

	// Key indexes (row * ROW_LENGTH + col) of the tracked modifier keys.
	localparam int KEY_CTRL  = 3 * ROW_LENGTH + 0;
	localparam int KEY_SHIFT = 2 * ROW_LENGTH + 1;
	localparam int KEY_FN    = 2 * ROW_LENGTH + 0;
	localparam int KEY_ALT   = 3 * ROW_LENGTH + 2;
	localparam int KEY_META  = 3 * ROW_LENGTH + 1;

	typedef logic [KEY_BITS-1:0] key_vec_t;

	typedef struct packed {
		logic                   event_valid;
		logic [ROW_W-1:0]       key_row;
		logic [COL_W-1:0]       key_col;
		logic                   key_pressed;
		logic [MOD_W-1:0]       modifier_bits;
		logic                   fn_held;
	} kmdr_result_t;

	// Active-low sense levels to the row/column key map (pure wiring).
	function automatic key_vec_t remap_levels(input logic [KEY_BITS-1:0] levels);
		key_vec_t keys;
		int       row;
		int       col;
		keys = '0;
		for (int s = 0; s < SELECT_COUNT; s++) begin
			for (int j = 0; j < SENSE_COUNT; j++) begin
				row = (ROW_COUNT - 1) - (s % ROW_COUNT);
				col = (s >= ROW_COUNT) ? (2 * j) : (2 * j + 1);
				keys[row * ROW_LENGTH + col] = ~levels[s * SENSE_COUNT + j];
			end
		end
		return keys;
	endfunction

	// Index of the single set bit of a one-hot vector; zero for an empty vector.
	function automatic logic [KEY_IDX_W-1:0] onehot_index(input key_vec_t onehot);
		logic [KEY_IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			idx = idx | ({KEY_IDX_W{onehot[i]}} & KEY_IDX_W'(i));
		end
		return idx;
	endfunction

	function automatic logic [ROW_W-1:0] key_row_of(input logic [KEY_IDX_W-1:0] idx);
		logic [ROW_W-1:0] row;
		if (idx >= KEY_IDX_W'(3 * ROW_LENGTH)) begin
			row = ROW_W'(3);
		end else if (idx >= KEY_IDX_W'(2 * ROW_LENGTH)) begin
			row = ROW_W'(2);
		end else if (idx >= KEY_IDX_W'(ROW_LENGTH)) begin
			row = ROW_W'(1);
		end else begin
			row = ROW_W'(0);
		end
		return row;
	endfunction

	function automatic logic [COL_W-1:0] key_col_of(input logic [KEY_IDX_W-1:0] idx,
			input logic [ROW_W-1:0] row);
		logic [KEY_IDX_W-1:0] base;
		logic [KEY_IDX_W-1:0] diff;
		case (row)
			ROW_W'(3): base = KEY_IDX_W'(3 * ROW_LENGTH);
			ROW_W'(2): base = KEY_IDX_W'(2 * ROW_LENGTH);
			ROW_W'(1): base = KEY_IDX_W'(ROW_LENGTH);
			default:   base = '0;
		endcase
		diff = idx - base;
		return diff[COL_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/kmdr_in_stage.sv
// Input register stage of the key matrix debounce reporter.
// Depends on kmdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kmdr_in_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [kmdr_pkg::TIME_W-1:0]     now_ms,
	input  logic [kmdr_pkg::KEY_BITS-1:0]   sense_levels,
	input  logic                            take,
	output logic                            valid_s1,
	output logic [kmdr_pkg::TIME_W-1:0]     now_ms_s1,
	output logic [kmdr_pkg::KEY_BITS-1:0]   sense_levels_s1
);

	logic load;

	// The stage can refill in the same cycle its item moves on.
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load || take) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			now_ms_s1       <= now_ms;
			sense_levels_s1 <= sense_levels;
		end
	end

	`ASSERT_NEXT(a_held_item_kept, clk, arst_n, valid_s1 && !take,
		valid_s1 && $stable(now_ms_s1) && $stable(sense_levels_s1))

endmodule

FILE: hw/rtl/kmdr_scan_core.sv
// Scan state, debounce, change search and report logic of the reporter.
// Depends on kmdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kmdr_scan_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [kmdr_pkg::PERIOD_W-1:0]       cfg_write_data,
	input  logic                                advance,
	input  logic [kmdr_pkg::TIME_W-1:0]         now_ms_s1,
	input  logic [kmdr_pkg::KEY_BITS-1:0]       sense_levels_s1,
	output kmdr_pkg::kmdr_result_t              result
);

	logic [kmdr_pkg::PERIOD_W-1:0]  scan_period_q;
	logic [kmdr_pkg::TIME_W-1:0]    last_scan_time_q;
	kmdr_pkg::key_vec_t             previous_raw_q;
	kmdr_pkg::key_vec_t             debounced_q;
	kmdr_pkg::key_vec_t             reported_q;

	logic [kmdr_pkg::TIME_W-1:0]    elapsed;
	logic                           scan_due;
	kmdr_pkg::key_vec_t             raw;
	kmdr_pkg::key_vec_t             agreed;
	kmdr_pkg::key_vec_t             debounced_next;
	kmdr_pkg::key_vec_t             changed;
	kmdr_pkg::key_vec_t             lowest;
	kmdr_pkg::key_vec_t             reported_next;
	logic [kmdr_pkg::KEY_IDX_W-1:0] key_idx;
	logic [kmdr_pkg::ROW_W-1:0]     row;

	assign elapsed  = now_ms_s1 - last_scan_time_q;
	assign scan_due = elapsed >= kmdr_pkg::TIME_W'(scan_period_q);

	assign raw    = kmdr_pkg::remap_levels(sense_levels_s1);
	assign agreed = ~(raw ^ previous_raw_q);

	// A key follows the raw level only when two consecutive scans agree.
	assign debounced_next = scan_due ? ((debounced_q & ~agreed) | (raw & agreed))
		: debounced_q;

	// Isolate the lowest differing key; an empty set gives index zero.
	assign changed       = reported_q ^ debounced_next;
	assign lowest        = changed & (~changed + kmdr_pkg::KEY_BITS'(1));
	assign reported_next = reported_q ^ lowest;
	assign key_idx       = kmdr_pkg::onehot_index(lowest);
	assign row           = kmdr_pkg::key_row_of(key_idx);

	// Held flags change only when their own key is reported, so they mirror
	// the reported set directly.
	always_comb begin
		result.event_valid   = |changed;
		result.key_row       = row;
		result.key_col       = kmdr_pkg::key_col_of(key_idx, row);
		result.key_pressed   = |(lowest & debounced_next);
		result.modifier_bits = {reported_next[kmdr_pkg::KEY_META],
			reported_next[kmdr_pkg::KEY_ALT],
			reported_next[kmdr_pkg::KEY_SHIFT],
			reported_next[kmdr_pkg::KEY_CTRL]};
		result.fn_held       = reported_next[kmdr_pkg::KEY_FN];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= kmdr_pkg::SCAN_PERIOD_RESET;
		end else if (cfg_write_en) begin
			scan_period_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_scan_time_q <= '0;
			previous_raw_q   <= '0;
			debounced_q      <= '0;
			reported_q       <= '0;
		end else if (advance) begin
			if (scan_due) begin
				last_scan_time_q <= now_ms_s1;
				previous_raw_q   <= raw;
			end
			debounced_q <= debounced_next;
			reported_q  <= reported_next;
		end
	end

	`ASSERT_NEXT(a_state_idle_hold, clk, arst_n, !advance,
		$stable(reported_q) && $stable(debounced_q) && $stable(previous_raw_q))
	`ASSERT_NEXT(a_event_toggles_one, clk, arst_n, advance && result.event_valid,
		$countones(reported_q ^ $past(reported_q)) == 1)

endmodule

FILE: hw/rtl/key_matrix_debounce_reporter.sv
// Top level of the key matrix debounce reporter: input stage, scan core and
// result register. Depends on kmdr_pkg, kmdr_in_stage, kmdr_scan_core, assert_macros.svh.
`include "assert_macros.svh"

// Every accepted item (a millisecond time and 56 active-low sense levels of an
// 8x7 key matrix) yields exactly one result: the lowest-indexed debounced key
// whose state differs from what was last reported, given as row, column and
// pressed, together with the held ctrl/shift/alt/meta and fn flags. A scan is
// taken only when scan_period_ms (reset 5) or more milliseconds have passed
// since the last taken scan, and a key changes its debounced state only after
// two consecutive taken scans agree. An item is held first in the input
// register and then in the result register; the whole debounce and change
// search runs in the single combinational pass between them, and one item is
// accepted every cycle while out_stall stays low. Write scan_period_ms only
// while no item is in flight.
module key_matrix_debounce_reporter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [kmdr_pkg::PERIOD_W-1:0]       cfg_write_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [kmdr_pkg::TIME_W-1:0]         now_ms,
	input  logic [kmdr_pkg::KEY_BITS-1:0]       sense_levels,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                event_valid,
	output logic [kmdr_pkg::ROW_W-1:0]          key_row,
	output logic [kmdr_pkg::COL_W-1:0]          key_col,
	output logic                                key_pressed,
	output logic [kmdr_pkg::MOD_W-1:0]          modifier_bits,
	output logic                                fn_held
);

	logic                               valid_s1;
	logic [kmdr_pkg::TIME_W-1:0]        now_ms_s1;
	logic [kmdr_pkg::KEY_BITS-1:0]      sense_levels_s1;
	logic                               advance;
	logic                               out_valid_q;
	kmdr_pkg::kmdr_result_t             result;
	kmdr_pkg::kmdr_result_t             result_q;

	// The item moves on when the result register is empty or being emptied.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);

	kmdr_in_stage u_in_stage (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.now_ms          (now_ms),
		.sense_levels    (sense_levels),
		.take            (advance),
		.valid_s1        (valid_s1),
		.now_ms_s1       (now_ms_s1),
		.sense_levels_s1 (sense_levels_s1)
	);

	kmdr_scan_core u_scan_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.advance         (advance),
		.now_ms_s1       (now_ms_s1),
		.sense_levels_s1 (sense_levels_s1),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_valid   = result_q.event_valid;
	assign key_row       = result_q.key_row;
	assign key_col       = result_q.key_col;
	assign key_pressed   = result_q.key_pressed;
	assign modifier_bits = result_q.modifier_bits;
	assign fn_held       = result_q.fn_held;

	`ASSERT_IMPLIES(a_stall_only_when_blocked, clk, arst_n, in_stall,
		valid_s1 && out_valid_q && out_stall)

endmodule

FILE: tb/kmdr_checker.sv
// Scoreboard for the key matrix debounce reporter: tracks scan-period writes and
// accepted items, predicts one result per item and compares it field by field.
// Depends on kmdr_pkg for widths, modifier key indexes and the result struct.
module kmdr_checker
	import kmdr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [PERIOD_W-1:0] cfg_write_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [TIME_W-1:0]   now_ms,
	input  key_vec_t            sense_levels,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                event_valid,
	input  logic [ROW_W-1:0]    key_row,
	input  logic [COL_W-1:0]    key_col,
	input  logic                key_pressed,
	input  logic [MOD_W-1:0]    modifier_bits,
	input  logic                fn_held,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MOD_CTRL_BIT  = 0;
	localparam int MOD_SHIFT_BIT = 1;
	localparam int MOD_ALT_BIT   = 2;
	localparam int MOD_META_BIT  = 3;
	localparam int PRINT_LIMIT   = 40;

	logic [PERIOD_W-1:0] scan_period;
	logic [TIME_W-1:0]   last_scan;
	key_vec_t            prior_raw;
	key_vec_t            debounced;
	key_vec_t            reported;
	logic [MOD_W-1:0]    held_mods;
	logic                fn_down;
	kmdr_result_t        expected_reports[$];
	int                  results_seen;

	// Takes a new scan when the period has passed, then reports the lowest key
	// whose debounced state differs from what has been reported so far.
	function automatic kmdr_result_t debounce_and_report(input logic [TIME_W-1:0] stamp,
			input key_vec_t levels);
		kmdr_result_t r;
		key_vec_t     raw;
		key_vec_t     agreed;
		key_vec_t     changed;
		logic [TIME_W-1:0] elapsed;
		int           hit;
		logic         down;
		r = '0;
		raw = '0;
		hit = -1;
		elapsed = stamp - last_scan;
		if (elapsed >= TIME_W'(scan_period)) begin
			for (int s = 0; s < SELECT_COUNT; s++) begin
				for (int j = 0; j < SENSE_COUNT; j++) begin
					raw[(3 - (s & 3)) * ROW_LENGTH + ((s > 3) ? 2 * j : 2 * j + 1)] =
						~levels[s * SENSE_COUNT + j];
				end
			end
			agreed = ~(raw ^ prior_raw);
			last_scan = stamp;
			prior_raw = raw;
			debounced = (debounced & ~agreed) | (raw & agreed);
		end
		changed = reported ^ debounced;
		for (int k = KEY_BITS - 1; k >= 0; k--) begin
			if (changed[k])
				hit = k;
		end
		if (hit >= 0) begin
			down = debounced[hit];
			reported[hit] = ~reported[hit];
			r.event_valid = 1'b1;
			r.key_row = ROW_W'(hit / ROW_LENGTH);
			r.key_col = COL_W'(hit % ROW_LENGTH);
			r.key_pressed = down;
			case (hit)
				KEY_CTRL:  held_mods[MOD_CTRL_BIT] = down;
				KEY_SHIFT: held_mods[MOD_SHIFT_BIT] = down;
				KEY_ALT:   held_mods[MOD_ALT_BIT] = down;
				KEY_META:  held_mods[MOD_META_BIT] = down;
				KEY_FN:    fn_down = down;
				default: ;
			endcase
		end
		r.modifier_bits = held_mods;
		r.fn_held = fn_down;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (fail_count < PRINT_LIMIT)
			$display("%0t: result %0d: %s is %0h, expected %0h", $realtime, results_seen,
				what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		kmdr_result_t want;
		if (!arst_n) begin
			scan_period = SCAN_PERIOD_RESET;
			last_scan = '0;
			prior_raw = '0;
			debounced = '0;
			reported = '0;
			held_mods = '0;
			fn_down = 1'b0;
			expected_reports.delete();
			results_seen = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_write_en)
				scan_period = cfg_write_data;
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("result with no item outstanding", 64'(1), 64'(0));
				end else begin
					want = expected_reports.pop_front();
					if (event_valid !== want.event_valid)
						report_mismatch("event_valid", 64'(event_valid),
							64'(want.event_valid));
					if (key_row !== want.key_row)
						report_mismatch("key_row", 64'(key_row), 64'(want.key_row));
					if (key_col !== want.key_col)
						report_mismatch("key_col", 64'(key_col), 64'(want.key_col));
					if (key_pressed !== want.key_pressed)
						report_mismatch("key_pressed", 64'(key_pressed),
							64'(want.key_pressed));
					if (modifier_bits !== want.modifier_bits)
						report_mismatch("modifier_bits", 64'(modifier_bits),
							64'(want.modifier_bits));
					if (fn_held !== want.fn_held)
						report_mismatch("fn_held", 64'(fn_held), 64'(want.fn_held));
				end
				results_seen++;
			end
			if (in_valid && !in_stall)
				expected_reports.push_back(debounce_and_report(now_ms, sense_levels));
			pending = expected_reports.size();
		end
	end

endmodule

FILE: tb/tb.sv
// Top of the key matrix debounce reporter testbench: clock, reset, item and
// result traffic with random idling, scan-period changes and the verdict.
// Depends on kmdr_pkg, key_matrix_debounce_reporter and kmdr_checker.
module tb;
	import kmdr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_COUNT      = 8;
	localparam int ITEMS_PER_PHASE  = 240;
	localparam int WRAP_PHASE       = 3;
	localparam int PAUSE_PHASE      = 2;
	localparam int LONG_HOLD_AT     = 400;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_SLACK      = 4;
	localparam int CYCLE_LIMIT      = 500000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write_en = 1'b0;
	logic [PERIOD_W-1:0] cfg_write_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [TIME_W-1:0]   now_ms = '0;
	key_vec_t            sense_levels = '1;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                event_valid;
	logic [ROW_W-1:0]    key_row;
	logic [COL_W-1:0]    key_col;
	logic                key_pressed;
	logic [MOD_W-1:0]    modifier_bits;
	logic                fn_held;

	int fail_count;
	int pending;
	int tx_idle_max = 0;
	int rx_idle_max = 0;
	int cycle_count = 0;
	int modifier_keys[5] = '{KEY_FN, KEY_SHIFT, KEY_CTRL, KEY_META, KEY_ALT};

	key_matrix_debounce_reporter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.now_ms        (now_ms),
		.sense_levels  (sense_levels),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_valid   (event_valid),
		.key_row       (key_row),
		.key_col       (key_col),
		.key_pressed   (key_pressed),
		.modifier_bits (modifier_bits),
		.fn_held       (fn_held)
	);

	kmdr_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.now_ms        (now_ms),
		.sense_levels  (sense_levels),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_valid   (event_valid),
		.key_row       (key_row),
		.key_col       (key_col),
		.key_pressed   (key_pressed),
		.modifier_bits (modifier_bits),
		.fn_held       (fn_held),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("key_matrix_debounce_reporter test failed");
			$finish;
		end
	end

	// Sense bit that reads the key at row-major index key: odd columns come from
	// the low four selects, even columns from the high four.
	function automatic int sense_bit_of(input int key);
		int row;
		int col;
		row = key / ROW_LENGTH;
		col = key % ROW_LENGTH;
		return ((col % 2) ? (3 - row) : (7 - row)) * SENSE_COUNT + col / 2;
	endfunction

	// Mostly holds the matrix steady so that keys settle across scans; now and
	// then flips one to three keys or a modifier, or redraws the whole matrix.
	function automatic key_vec_t next_matrix_levels(input key_vec_t levels);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return levels;
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 3))
				levels[$urandom_range(0, KEY_BITS - 1)] ^= 1'b1;
		end else if (pick < 88) begin
			levels[sense_bit_of(modifier_keys[$urandom_range(0, 4)])] ^= 1'b1;
		end else if (pick < 93) begin
			levels = KEY_BITS'({$urandom, $urandom});
		end else if (pick < 96) begin
			levels = '1;
		end else begin
			levels = '0;
		end
		return levels;
	endfunction

	task automatic offer_item(input logic [TIME_W-1:0] stamp, input key_vec_t levels);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= stamp;
		sense_levels <= levels;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stops offering and waits until every outstanding item has its result.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_scan_period(input logic [PERIOD_W-1:0] period);
		cfg_write_en <= 1'b1;
		cfg_write_data <= period;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Receiver: after each result it stalls for a drawn number of cycles, and
	// once it holds off long enough for the block to back up into its input.
	initial begin : receiver
		int rx_wait;
		int results_taken;
		rx_wait = 0;
		results_taken = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && !out_stall) begin
					results_taken++;
					rx_wait = (results_taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
						: $urandom_range(0, rx_idle_max);
				end else if (rx_wait != 0) begin
					rx_wait--;
				end
				out_stall <= (rx_wait != 0);
			end
		end
	end

	initial begin : sender
		logic [PERIOD_W-1:0] phase_periods[PHASE_COUNT];
		logic [TIME_W-1:0]   stamp;
		key_vec_t            levels;
		key_vec_t            mods_down;
		key_vec_t            corners_down;
		phase_periods = '{8'd1, 8'd255, 8'd0, 8'd5, 8'd0, 8'd0, 8'd40, 8'd2};
		phase_periods[4] = PERIOD_W'($urandom_range(1, 255));
		phase_periods[5] = PERIOD_W'($urandom_range(1, 255));
		mods_down = '1;
		foreach (modifier_keys[m])
			mods_down[sense_bit_of(modifier_keys[m])] = 1'b0;
		corners_down = '1;
		corners_down[sense_bit_of(0)] = 1'b0;
		corners_down[sense_bit_of(KEY_BITS - 1)] = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset scan period of 5 ms.
		offer_item(32'd0, '1);
		offer_item(32'd3, mods_down);
		offer_item(32'd5, mods_down);
		repeat (6) offer_item(32'd10, mods_down);
		offer_item(32'd15, '1);
		repeat (5) offer_item(32'd20, '1);
		offer_item(32'd25, corners_down);
		repeat (2) offer_item(32'd30, corners_down);
		levels = corners_down;
		levels[sense_bit_of(KEY_BITS - 1)] = 1'b1;
		// The bottom right key bounces, so it must keep its debounced state.
		offer_item(32'd35, levels);
		offer_item(32'd40, corners_down);
		// Across the time wrap: 4 ms is too short, 5 ms takes the scan.
		offer_item(32'hFFFF_FFFE, '1);
		offer_item(32'h0000_0002, '1);
		repeat (2) offer_item(32'h0000_0003, '1);
		offer_item(32'h0000_0100, '0);

		stamp = 32'h0000_0100;
		levels = '0;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			write_scan_period(phase_periods[p]);
			tx_idle_max = (p % 2 == 1) ? 15 : 0;
			rx_idle_max = (p % 4 >= 2) ? 15 : 0;
			if (p == WRAP_PHASE)
				stamp = 32'hFFFF_FE00;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
					drain_results();
				if ($urandom_range(0, 99) < 3)
					stamp = $urandom;
				else
					stamp = stamp + $urandom_range(0, 2 * int'(phase_periods[p]) + 2);
				levels = next_matrix_levels(levels);
				offer_item(stamp, levels);
			end
		end

		drain_results();
		if (fail_count == 0 && pending == 0)
			$display("key_matrix_debounce_reporter test passed");
		else
			$display("key_matrix_debounce_reporter test failed");
		$finish;
	end

endmodule

FILE: key_matrix_debounce_reporter.f
+incdir+hw/rtl
hw/rtl/kmdr_pkg.sv
hw/rtl/kmdr_in_stage.sv
hw/rtl/kmdr_scan_core.sv
hw/rtl/key_matrix_debounce_reporter.sv
tb/kmdr_checker.sv
tb/tb.sv
